### src/assert_macros.svh
// Assertion macros shared by the checker file.
// Depends on nothing; each macro expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is low
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("port check failed");

// Condition that must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, bad) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(bad)) \
    else $error("forbidden condition seen");

`endif

### src/mrdr_pkg.sv
// Types and constants for the mixed-radix digit-reversal block.
// Used by every module of the block; depends on nothing.
`default_nettype none
package mrdr_pkg;

  localparam int unsigned IDX_W        = 20;
  localparam int unsigned RADIX_W      = 16;
  localparam int unsigned MAX_STAGES   = 6;
  localparam int unsigned CNT_W        = 3;
  localparam int unsigned BITS_PER_STG = 4;
  localparam int unsigned DIV_STGS     = IDX_W / BITS_PER_STG;
  localparam int unsigned LATENCY      = MAX_STAGES * (DIV_STGS + 1) + 1;
  localparam int unsigned PROD_W       = IDX_W + 1;
  localparam int unsigned ADDR_W       = 5;
  localparam int unsigned DATA_W       = 32;

  localparam logic [PROD_W-1:0] PROD_LIMIT = {1'b1, {IDX_W{1'b0}}};
  localparam logic [PROD_W-1:0] PROD_SAT   = {1'b1, {(IDX_W-1){1'b0}}, 1'b1};

  typedef enum logic [2:0] {
    REG_STAGE_COUNT = 3'd0,
    REG_RADIX_A     = 3'd1,
    REG_RADIX_B     = 3'd2,
    REG_RADIX_C     = 3'd3,
    REG_RADIX_D     = 3'd4,
    REG_RADIX_E     = 3'd5,
    REG_RADIX_F     = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] index_in;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] permuted_index;
    logic             out_of_range;
  } rsp_t;

  // Work carried down the pipeline: quotient so far and rebuilt index
  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] v;
    logic [IDX_W-1:0] res;
  } pipe_t;

endpackage
`default_nettype wire

### src/mrdr_digit.sv
// One digit step: pipelined restoring divide of v by the radix, then res = res*radix + digit.
// Depends on mrdr_pkg.
`default_nettype none
module mrdr_digit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  input  wire mrdr_pkg::pipe_t               data_i,
  input  wire logic [mrdr_pkg::RADIX_W-1:0]  div_fwd_i,
  input  wire logic [mrdr_pkg::RADIX_W-1:0]  div_inv_i,
  output logic                               valid_o,
  output mrdr_pkg::pipe_t                    data_o
);

  logic                           valid_q [mrdr_pkg::DIV_STGS+1];
  mrdr_pkg::pipe_t                data_q  [mrdr_pkg::DIV_STGS+1];
  logic [mrdr_pkg::RADIX_W-1:0]   rem_q   [mrdr_pkg::DIV_STGS+1];

  always_comb begin
    valid_q[0] = valid_i;
    data_q[0]  = data_i;
    rem_q[0]   = '0;
  end

  for (genvar s = 0; s < mrdr_pkg::DIV_STGS; s++) begin : g_div
    mrdr_pkg::pipe_t              data_d;
    logic [mrdr_pkg::RADIX_W-1:0] rem_d;
    logic                         valid_r;
    mrdr_pkg::pipe_t              data_r;
    logic [mrdr_pkg::RADIX_W-1:0] rem_r;

    always_comb begin
      logic [mrdr_pkg::RADIX_W:0]   trial;
      logic [mrdr_pkg::RADIX_W-1:0] dv;
      dv     = data_q[s].kind ? div_inv_i : div_fwd_i;
      data_d = data_q[s];
      rem_d  = rem_q[s];
      for (int b = 0; b < mrdr_pkg::BITS_PER_STG; b++) begin
        trial = {rem_d, data_d.v[mrdr_pkg::IDX_W-1]};
        if (trial >= {1'b0, dv}) begin
          trial = trial - {1'b0, dv};
          data_d.v = {data_d.v[mrdr_pkg::IDX_W-2:0], 1'b1};
        end else begin
          data_d.v = {data_d.v[mrdr_pkg::IDX_W-2:0], 1'b0};
        end
        rem_d = trial[mrdr_pkg::RADIX_W-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_r <= 1'b0;
      end else begin
        valid_r <= valid_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      data_r <= data_d;
      rem_r  <= rem_d;
    end

    always_comb begin
      valid_q[s+1] = valid_r;
      data_q[s+1]  = data_r;
      rem_q[s+1]   = rem_r;
    end
  end

  // Horner step on the remainder just produced
  logic                                        valid_q2;
  mrdr_pkg::pipe_t                             mac_d, mac_q;
  logic [mrdr_pkg::RADIX_W-1:0]                mac_div;
  logic [mrdr_pkg::IDX_W+mrdr_pkg::RADIX_W-1:0] prod_full;

  always_comb begin
    mac_div   = data_q[mrdr_pkg::DIV_STGS].kind ? div_inv_i : div_fwd_i;
    prod_full = data_q[mrdr_pkg::DIV_STGS].res * mac_div;
    mac_d     = data_q[mrdr_pkg::DIV_STGS];
    mac_d.res = prod_full[mrdr_pkg::IDX_W-1:0]
              + {{(mrdr_pkg::IDX_W-mrdr_pkg::RADIX_W){1'b0}}, rem_q[mrdr_pkg::DIV_STGS]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q2 <= 1'b0;
    end else begin
      valid_q2 <= valid_q[mrdr_pkg::DIV_STGS];
    end
  end

  always_ff @(posedge clk_i) begin
    mac_q <= mac_d;
  end

  assign valid_o = valid_q2;
  assign data_o  = mac_q;

endmodule
`default_nettype wire

### src/mixed_radix_digit_reversal_top.sv
// Path from an accepted request to done_o: six digit steps of six stages, plus the output
// register. Throughput: one request per cycle; busy stays low.
// Each digit step is a five-stage divider (four quotient bits a stage) and a multiply-add.
// Reset: stage_count = 1, all radices = 2, pipeline valid bits cleared; no clearing pass.
// Config registers via APB at 4*index; depends on mrdr_pkg and mrdr_digit.
`default_nettype none
module mixed_radix_digit_reversal_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire mrdr_pkg::req_t                req_i,
  output logic                               done_o,
  output mrdr_pkg::rsp_t                     rsp_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mrdr_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [mrdr_pkg::DATA_W-1:0]   pwdata,
  output logic [mrdr_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  logic [mrdr_pkg::CNT_W-1:0]   stage_count_q;
  logic [mrdr_pkg::RADIX_W-1:0] radix_q [mrdr_pkg::MAX_STAGES];
  logic [mrdr_pkg::CNT_W-1:0]   n_use;
  logic                         wr_en;
  mrdr_pkg::reg_idx_e           reg_idx;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = mrdr_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_count_q <= mrdr_pkg::CNT_W'(1);
      for (int i = 0; i < mrdr_pkg::MAX_STAGES; i++) begin
        radix_q[i] <= mrdr_pkg::RADIX_W'(2);
      end
    end else if (wr_en) begin
      case (reg_idx)
        mrdr_pkg::REG_STAGE_COUNT: stage_count_q <= pwdata[mrdr_pkg::CNT_W-1:0];
        mrdr_pkg::REG_RADIX_A:     radix_q[0] <= pwdata[mrdr_pkg::RADIX_W-1:0];
        mrdr_pkg::REG_RADIX_B:     radix_q[1] <= pwdata[mrdr_pkg::RADIX_W-1:0];
        mrdr_pkg::REG_RADIX_C:     radix_q[2] <= pwdata[mrdr_pkg::RADIX_W-1:0];
        mrdr_pkg::REG_RADIX_D:     radix_q[3] <= pwdata[mrdr_pkg::RADIX_W-1:0];
        mrdr_pkg::REG_RADIX_E:     radix_q[4] <= pwdata[mrdr_pkg::RADIX_W-1:0];
        mrdr_pkg::REG_RADIX_F:     radix_q[5] <= pwdata[mrdr_pkg::RADIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mrdr_pkg::REG_STAGE_COUNT:
        prdata = {{(mrdr_pkg::DATA_W-mrdr_pkg::CNT_W){1'b0}}, stage_count_q};
      mrdr_pkg::REG_RADIX_A: prdata = {{(mrdr_pkg::DATA_W-mrdr_pkg::RADIX_W){1'b0}}, radix_q[0]};
      mrdr_pkg::REG_RADIX_B: prdata = {{(mrdr_pkg::DATA_W-mrdr_pkg::RADIX_W){1'b0}}, radix_q[1]};
      mrdr_pkg::REG_RADIX_C: prdata = {{(mrdr_pkg::DATA_W-mrdr_pkg::RADIX_W){1'b0}}, radix_q[2]};
      mrdr_pkg::REG_RADIX_D: prdata = {{(mrdr_pkg::DATA_W-mrdr_pkg::RADIX_W){1'b0}}, radix_q[3]};
      mrdr_pkg::REG_RADIX_E: prdata = {{(mrdr_pkg::DATA_W-mrdr_pkg::RADIX_W){1'b0}}, radix_q[4]};
      mrdr_pkg::REG_RADIX_F: prdata = {{(mrdr_pkg::DATA_W-mrdr_pkg::RADIX_W){1'b0}}, radix_q[5]};
      default:               prdata = '0;
    endcase
  end

  // Zero means one, above the maximum saturates
  always_comb begin
    if (stage_count_q == '0) begin
      n_use = mrdr_pkg::CNT_W'(1);
    end else if (stage_count_q > mrdr_pkg::CNT_W'(mrdr_pkg::MAX_STAGES)) begin
      n_use = mrdr_pkg::CNT_W'(mrdr_pkg::MAX_STAGES);
    end else begin
      n_use = stage_count_q;
    end
  end

  // Radix product, one multiply per register; settles well before any request reaches the end
  logic [mrdr_pkg::PROD_W-1:0] prod_q [mrdr_pkg::MAX_STAGES];

  for (genvar k = 0; k < mrdr_pkg::MAX_STAGES; k++) begin : g_prod
    logic [mrdr_pkg::PROD_W-1:0]                  prev;
    logic [mrdr_pkg::PROD_W+mrdr_pkg::RADIX_W-1:0] mul;
    logic [mrdr_pkg::PROD_W-1:0]                  prod_d;

    if (k == 0) begin : g_first
      assign prev = mrdr_pkg::PROD_W'(1);
    end else begin : g_next
      assign prev = prod_q[k-1];
    end

    always_comb begin
      mul = prev * radix_q[k];
      if (mrdr_pkg::CNT_W'(k) >= n_use) begin
        prod_d = prev;
      end else if (mul > {{mrdr_pkg::RADIX_W{1'b0}}, mrdr_pkg::PROD_LIMIT}) begin
        prod_d = mrdr_pkg::PROD_SAT;
      end else begin
        prod_d = mul[mrdr_pkg::PROD_W-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        prod_q[k] <= mrdr_pkg::PROD_W'(2);
      end else begin
        prod_q[k] <= prod_d;
      end
    end
  end

  // Digit steps
  logic            dig_valid [mrdr_pkg::MAX_STAGES+1];
  mrdr_pkg::pipe_t dig_data  [mrdr_pkg::MAX_STAGES+1];

  always_comb begin
    dig_valid[0]         = start && !busy;
    dig_data[0].kind     = req_i.kind;
    dig_data[0].idx      = req_i.index_in;
    dig_data[0].v        = req_i.index_in;
    dig_data[0].res      = '0;
  end

  for (genvar k = 0; k < mrdr_pkg::MAX_STAGES; k++) begin : g_digit
    logic [mrdr_pkg::CNT_W-1:0]   rev_idx;
    logic [mrdr_pkg::RADIX_W-1:0] div_fwd;
    logic [mrdr_pkg::RADIX_W-1:0] div_inv;

    always_comb begin
      rev_idx = n_use - mrdr_pkg::CNT_W'(1) - mrdr_pkg::CNT_W'(k);
      if (mrdr_pkg::CNT_W'(k) < n_use) begin
        div_fwd = radix_q[k];
        div_inv = radix_q[rev_idx];
      end else begin
        div_fwd = mrdr_pkg::RADIX_W'(1);
        div_inv = mrdr_pkg::RADIX_W'(1);
      end
    end

    mrdr_digit u_digit (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (dig_valid[k]),
      .data_i    (dig_data[k]),
      .div_fwd_i (div_fwd),
      .div_inv_i (div_inv),
      .valid_o   (dig_valid[k+1]),
      .data_o    (dig_data[k+1])
    );
  end

  // Range check and output register
  mrdr_pkg::pipe_t fin;
  logic            oor;
  logic            done_q;
  mrdr_pkg::rsp_t  rsp_d, rsp_q;
  logic [mrdr_pkg::PROD_W-1:0] prod_fin;

  always_comb begin
    fin      = dig_data[mrdr_pkg::MAX_STAGES];
    prod_fin = prod_q[mrdr_pkg::MAX_STAGES-1];
    oor      = (prod_fin == '0) || (prod_fin > mrdr_pkg::PROD_LIMIT)
            || ({1'b0, fin.idx} >= prod_fin);
    rsp_d.out_of_range   = oor;
    rsp_d.permuted_index = oor ? '0 : fin.res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dig_valid[mrdr_pkg::MAX_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
`default_nettype wire

### src/mrdr_checker.sv
// Port-level checks for the digit-reversal top level, attached by bind.
// Depends on mrdr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module mrdr_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           done_o,
  input wire mrdr_pkg::rsp_t rsp_o,
  input wire logic           pready
);

  `ASSERT_CLK(a_req_done, (start && !busy) |-> ##(mrdr_pkg::LATENCY) done_o)
  `ASSERT_CLK(a_idle_quiet, !(start && !busy) |-> ##(mrdr_pkg::LATENCY) !done_o)
  `ASSERT_NEVER(a_oor_zero, done_o && rsp_o.out_of_range && (rsp_o.permuted_index != '0))
  `ASSERT_CLK(a_pready, pready)

endmodule

bind mixed_radix_digit_reversal_top mrdr_checker u_mrdr_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o),
  .pready (pready)
);
`default_nettype wire
